[hdl/delayed_frame_release_queue_unit_macros.svh]
// Assertion macros shared by the checking code of the release queue.
`ifndef DELAYED_FRAME_RELEASE_QUEUE_UNIT_MACROS_SVH
`define DELAYED_FRAME_RELEASE_QUEUE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DFRQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DFRQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/dfrq_pkg.sv]
`timescale 1ns / 1ps
package dfrq_pkg;

  // Default number of pending frames held.
  localparam int CAPACITY_DEF = 64;

  // Field widths of one transaction.
  localparam int MODE_W    = 2;
  localparam int DELAY_W   = 24;
  localparam int ID_W      = 32;
  localparam int LENGTH_W  = 4;
  localparam int PAYLOAD_W = 64;
  localparam int TIME_W    = 32;

  // Operation codes carried in the mode field.
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // One stored entry.
  typedef struct packed {
    logic [TIME_W-1:0]    wake;
    logic [ID_W-1:0]      id;
    logic [LENGTH_W-1:0]  length;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic push;
    logic clear;
    logic tick;
    logic pass_init;
    logic scan;
    logic emit;
    logic compact_init;
    logic compact;
    logic compact_end;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_done;
    logic none_left;
    logic out_free;
  } stat_t;

endpackage

[hdl/dfrq_if.sv]
`timescale 1ns / 1ps
// Input channel: one operation per transaction.
interface dfrq_in_if;
  logic                           valid;
  logic                           ready;
  logic [dfrq_pkg::MODE_W-1:0]    mode;
  logic [dfrq_pkg::DELAY_W-1:0]   delay_ticks;
  logic [dfrq_pkg::ID_W-1:0]      frame_id;
  logic [dfrq_pkg::LENGTH_W-1:0]  frame_length;
  logic [dfrq_pkg::PAYLOAD_W-1:0] frame_payload;

  modport source (output valid, mode, delay_ticks, frame_id, frame_length, frame_payload,
                  input ready);
  modport sink (input valid, mode, delay_ticks, frame_id, frame_length, frame_payload,
                output ready);
endinterface

// Output channel: one released frame per transaction.
interface dfrq_out_if;
  logic                           valid;
  logic                           ready;
  logic [dfrq_pkg::ID_W-1:0]      out_id;
  logic [dfrq_pkg::LENGTH_W-1:0]  out_length;
  logic [dfrq_pkg::PAYLOAD_W-1:0] out_payload;
  logic                           last_release;

  modport source (output valid, out_id, out_length, out_payload, last_release, input ready);
  modport sink (input valid, out_id, out_length, out_payload, last_release, output ready);
endinterface

[hdl/dfrq_ram.sv]
`timescale 1ns / 1ps
// Simple dual-port RAM with a registered read.
module dfrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/dfrq_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer: accepts operations, runs release passes and the repacking walk.
module dfrq_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [dfrq_pkg::MODE_W-1:0] in_mode,
  input  dfrq_pkg::stat_t             stat,
  output logic                        in_ready,
  output dfrq_pkg::cmd_t              cmd
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_SCAN    = 2'd1;
  localparam logic [1:0] S_EMIT    = 2'd2;
  localparam logic [1:0] S_COMPACT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.push  = (in_mode == dfrq_pkg::MODE_PUSH);
          cmd.clear = (in_mode == dfrq_pkg::MODE_CLEAR);
          if (in_mode == dfrq_pkg::MODE_TICK) begin
            cmd.tick      = 1'b1;
            cmd.pass_init = 1'b1;
            state_next    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.walk_done) begin
          if (stat.none_left) begin
            cmd.compact_init = 1'b1;
            state_next       = S_COMPACT;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.pass_init = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_COMPACT: begin
        cmd.compact = 1'b1;
        if (stat.walk_done) begin
          cmd.compact_end = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hdl/dfrq_datapath.sv]
`timescale 1ns / 1ps
`include "delayed_frame_release_queue_unit_macros.svh"
// Entry store, time base, selection of the oldest expired entry and output register.
module dfrq_datapath #(
  parameter int CAPACITY = dfrq_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  dfrq_pkg::cmd_t                 cmd,
  input  logic [dfrq_pkg::DELAY_W-1:0]   delay_ticks,
  input  logic [dfrq_pkg::ID_W-1:0]      frame_id,
  input  logic [dfrq_pkg::LENGTH_W-1:0]  frame_length,
  input  logic [dfrq_pkg::PAYLOAD_W-1:0] frame_payload,
  output dfrq_pkg::stat_t                stat,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dfrq_pkg::ID_W-1:0]      out_id,
  output logic [dfrq_pkg::LENGTH_W-1:0]  out_length,
  output logic [dfrq_pkg::PAYLOAD_W-1:0] out_payload,
  output logic                           last_release
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [dfrq_pkg::TIME_W-1:0] cur_time;
  logic [CW-1:0]               count;
  logic [AW-1:0]               oldest;
  logic [CW-1:0]               rd_pos;
  logic [CW-1:0]               wr_k;
  logic [CW-1:0]               remaining;
  logic                        v1;
  logic [AW-1:0]               pos1;
  logic [CAPACITY-1:0]         done;
  logic                        found;
  logic [dfrq_pkg::TIME_W-1:0] best_age;
  logic [AW-1:0]               best_pos;
  dfrq_pkg::entry_t            best_entry;

  logic                        issue;
  logic [AW-1:0]               raddr;
  logic                        we;
  logic [AW-1:0]               waddr;
  dfrq_pkg::entry_t            wdata;
  dfrq_pkg::entry_t            rdata;
  logic [dfrq_pkg::TIME_W-1:0] age;
  logic                        expired;
  logic                        full;

  // Ring position to physical slot.
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base, input logic [AW-1:0] pos);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, pos};
    if (s >= (AW+1)'(CAPACITY)) begin
      s = s - (AW+1)'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  dfrq_ram #(
    .WIDTH (dfrq_pkg::ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Walk reads and expiry test on the returned entry.
  assign issue   = (cmd.scan || cmd.compact) && (rd_pos < count);
  assign raddr   = slot_of(oldest, rd_pos[AW-1:0]);
  assign age     = cur_time - rdata.wake;
  assign expired = (age != '0) && !age[dfrq_pkg::TIME_W-1];
  assign full    = (count >= CW'(CAPACITY));

  // Write port: a push, or a surviving entry moved down during repacking.
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    if (cmd.push) begin
      we            = 1'b1;
      waddr         = full ? oldest : slot_of(oldest, count[AW-1:0]);
      wdata.wake    = cur_time + dfrq_pkg::TIME_W'(delay_ticks);
      wdata.id      = frame_id;
      wdata.length  = frame_length;
      wdata.payload = frame_payload;
    end else if (cmd.compact && v1 && !expired) begin
      we    = 1'b1;
      waddr = slot_of(oldest, wr_k[AW-1:0]);
    end
  end

  assign stat.walk_done = (rd_pos == count) && !v1;
  assign stat.none_left = (remaining == '0);
  assign stat.out_free  = !out_valid || out_ready;

  // Control registers of the store and the walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_time  <= '0;
      count     <= '0;
      oldest    <= '0;
      rd_pos    <= '0;
      wr_k      <= '0;
      remaining <= '0;
      v1        <= 1'b0;
      done      <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= issue;
      if (issue) begin
        rd_pos <= rd_pos + 1'b1;
      end
      if (cmd.push) begin
        if (full) begin
          oldest <= (oldest == AW'(CAPACITY - 1)) ? '0 : oldest + 1'b1;
        end else begin
          count <= count + 1'b1;
        end
      end
      if (cmd.clear) begin
        count  <= '0;
        oldest <= '0;
      end
      if (cmd.tick) begin
        cur_time <= cur_time + 1'b1;
        done     <= '0;
      end
      if (cmd.pass_init) begin
        rd_pos    <= '0;
        remaining <= '0;
        found     <= 1'b0;
      end
      // Count the expired entries still pending in this pass.
      if (cmd.scan && v1 && expired && !done[pos1]) begin
        remaining <= remaining + 1'b1;
        if (!found || age > best_age) begin
          found <= 1'b1;
        end
      end
      if (cmd.emit) begin
        done[best_pos] <= 1'b1;
      end
      if (cmd.compact_init) begin
        rd_pos <= '0;
        wr_k   <= '0;
      end
      if (cmd.compact && v1 && !expired) begin
        wr_k <= wr_k + 1'b1;
      end
      if (cmd.compact_end) begin
        count <= wr_k;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: best candidate and output transaction.
  always_ff @(posedge clk) begin
    pos1 <= rd_pos[AW-1:0];
    if (cmd.scan && v1 && expired && !done[pos1] && (!found || age > best_age)) begin
      best_age   <= age;
      best_pos   <= pos1;
      best_entry <= rdata;
    end
    if (cmd.emit) begin
      out_id       <= best_entry.id;
      out_length   <= best_entry.length;
      out_payload  <= best_entry.payload;
      last_release <= (remaining == CW'(1));
    end
  end

  `DFRQ_ASSERT_SAME(a_count_range, 1'b1, count <= CW'(CAPACITY), "entry count above capacity")
  `DFRQ_ASSERT_SAME(a_emit_found, cmd.emit, found && (remaining != '0), "release without candidate")
  `DFRQ_ASSERT_NEXT(a_compact_shrinks, cmd.compact_end, count <= $past(count), "repack grew store")

endmodule

[hdl/delayed_frame_release_queue_unit.sv]
`timescale 1ns / 1ps
// Channel   Dir  Fields
// in_item   in   mode, delay_ticks, frame_id, frame_length, frame_payload
// out_item  out  out_id, out_length, out_payload, last_release
//
// Push, clear and the unused mode do not block the input. After a tick is accepted the input
// stays blocked until all passes are done. Each release costs one walk through the entry
// RAM to find the oldest pending expired entry, and one step that loads the output register.
// A further walk finds no pending expired entry left and ends the release passes.
// A final walk repacks the survivors. Reset (rst, synchronous) empties the store.
// Reset also zeroes the time base. A stalled output holds the sequencer before the next pass.
module delayed_frame_release_queue_unit #(
  parameter int CAPACITY = dfrq_pkg::CAPACITY_DEF
) (
  input logic        clk,
  input logic        rst,
  dfrq_in_if.sink    in_item,
  dfrq_out_if.source out_item
);

  dfrq_pkg::cmd_t  cmd;
  dfrq_pkg::stat_t stat;

  dfrq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_item.valid),
    .in_mode  (in_item.mode),
    .stat     (stat),
    .in_ready (in_item.ready),
    .cmd      (cmd)
  );

  dfrq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .delay_ticks   (in_item.delay_ticks),
    .frame_id      (in_item.frame_id),
    .frame_length  (in_item.frame_length),
    .frame_payload (in_item.frame_payload),
    .stat          (stat),
    .out_valid     (out_item.valid),
    .out_ready     (out_item.ready),
    .out_id        (out_item.out_id),
    .out_length    (out_item.out_length),
    .out_payload   (out_item.out_payload),
    .last_release  (out_item.last_release)
  );

endmodule
